// ===== src/sfrt_pkg.sv =====
// Shared types and constants for the sorted flow route table.
// Used by sfrt_cell, sfrt_merge and sorted_flow_route_table; no dependencies.
package sfrt_pkg;

    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // item function codes
    localparam logic [1:0] FN_FIND   = 2'd0;
    localparam logic [1:0] FN_INSERT = 2'd1;
    localparam logic [1:0] FN_LEARN  = 2'd2;
    localparam logic [1:0] FN_SWEEP  = 2'd3;

    // result status codes
    localparam logic [2:0] STS_FOUND    = 3'd0;
    localparam logic [2:0] STS_INSERTED = 3'd1;
    localparam logic [2:0] STS_ABSENT   = 3'd2;
    localparam logic [2:0] STS_FULL     = 3'd3;
    localparam logic [2:0] STS_SWEPT    = 3'd4;
    localparam logic [2:0] STS_SKIPPED  = 3'd5;

    // configuration register indexes and reset values
    localparam logic CFG_ALIVE = 1'b0;
    localparam logic CFG_SWEEP = 1'b1;
    localparam logic [23:0] ALIVE_RESET = 24'd30000;
    localparam logic [23:0] SWEEP_RESET = 24'd1000;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] client_ip;
        logic [15:0] client_port;
        logic [31:0] gateway_ip;
        logic [15:0] gateway_port;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] route_ip;
        logic [15:0] route_port;
        logic [31:0] last_receive;
        logic [10:0] occupancy;
        logic [10:0] removed_count;
    } t_out_item;

    typedef struct packed {
        logic [47:0] key;
        logic [47:0] gw;
        logic [31:0] act;
        logic [31:0] rx;
    } t_entry;

    typedef struct packed {
        logic start;
        logic step;
        logic head_vld;
        logic ins_ok;
        logic sweep;
    } t_merge_ctl;

    typedef struct packed {
        logic             found;
        logic             inserted;
        logic [47:0]      gw;
        logic [31:0]      rx;
        logic [CNT_W-1:0] removed;
    } t_merge_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

endpackage

// ===== src/sfrt_cell.sv =====
// One table slot of the entry ring: loads a new entry or takes its neighbor's.
// Depends on sfrt_pkg.
module sfrt_cell import sfrt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_shift,
    input  logic   i_load,
    input  t_entry i_next,
    input  t_entry i_wdata,
    output t_entry o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_wdata;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== src/sfrt_merge.sv =====
// Head-of-ring unit: looks at the entry leaving the ring each step and decides
// what goes back in (kept, updated, dropped, or new entry spliced in front).
// Depends on sfrt_pkg.
module sfrt_merge import sfrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_merge_ctl  i_ctl,
    input  t_in_item    i_item,
    input  logic [23:0] i_alive,
    input  t_entry      i_head,
    output logic        o_wr,
    output t_entry      o_entry,
    output t_merge_res  o_res
);

    logic             r_delayed;
    logic             r_found;
    logic             r_inserted;
    logic [CNT_W-1:0] r_removed;
    t_entry           r_d;
    logic [47:0]      r_gw;
    logic [31:0]      r_rx;

    logic [47:0] w_key;
    t_entry      w_new;
    t_entry      w_upd;
    logic        w_gt;
    logic        w_eq;
    logic [31:0] w_idle;
    logic        w_alive;
    logic        w_take_d;
    logic        w_set_ins;
    logic        w_set_found;
    logic        w_drop;

    assign w_key = {i_item.client_ip, i_item.client_port};

    always_comb begin
        w_new.key = w_key;
        w_new.gw  = {i_item.gateway_ip, i_item.gateway_port};
        w_new.act = i_item.now;
        w_new.rx  = i_item.now;

        w_upd     = i_head;
        w_upd.act = i_item.now;
        if (i_item.func == FN_LEARN) begin
            w_upd.gw = {i_item.gateway_ip, i_item.gateway_port};
            w_upd.rx = i_item.now;
        end
    end

    assign w_gt    = i_head.key > w_key;
    assign w_eq    = i_head.key == w_key;
    assign w_idle  = i_item.now - i_head.act;
    assign w_alive = w_idle < {8'd0, i_alive};

    always_comb begin
        o_wr        = 1'b0;
        o_entry     = i_head;
        w_take_d    = 1'b0;
        w_set_ins   = 1'b0;
        w_set_found = 1'b0;
        w_drop      = 1'b0;
        if (i_ctl.sweep) begin
            o_wr   = i_ctl.head_vld & w_alive;
            w_drop = i_ctl.head_vld & ~w_alive;
        end else if (r_delayed) begin
            // after a splice the stream runs one entry late
            o_wr     = 1'b1;
            o_entry  = r_d;
            w_take_d = i_ctl.head_vld;
        end else if (i_ctl.head_vld) begin
            o_wr = 1'b1;
            if (i_ctl.ins_ok && !r_found && w_gt) begin
                o_entry   = w_new;
                w_take_d  = 1'b1;
                w_set_ins = 1'b1;
            end else if (w_eq) begin
                o_entry     = w_upd;
                w_set_found = 1'b1;
            end
        end else if (i_ctl.ins_ok && !r_found) begin
            // new key sorts past every entry
            o_wr      = 1'b1;
            o_entry   = w_new;
            w_set_ins = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delayed  <= 1'b0;
            r_found    <= 1'b0;
            r_inserted <= 1'b0;
            r_removed  <= '0;
        end else if (i_ctl.start) begin
            r_delayed  <= 1'b0;
            r_found    <= 1'b0;
            r_inserted <= 1'b0;
            r_removed  <= '0;
        end else if (i_ctl.step) begin
            if (w_set_ins) begin
                r_inserted <= 1'b1;
                r_delayed  <= 1'b1;
            end
            if (w_set_found) begin
                r_found <= 1'b1;
            end
            if (w_drop) begin
                r_removed <= r_removed + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (w_take_d) begin
                r_d <= i_head;
            end
            if (w_set_found) begin
                r_gw <= w_upd.gw;
                r_rx <= w_upd.rx;
            end
        end
    end

    always_comb begin
        o_res.found    = r_found;
        o_res.inserted = r_inserted;
        o_res.gw       = r_gw;
        o_res.rx       = r_rx;
        o_res.removed  = r_removed;
    end

endmodule

// ===== src/sorted_flow_route_table.sv =====
// Sorted flow route table: top level with control, ring of entry cells and
// the head merge unit. Depends on sfrt_pkg, sfrt_cell and sfrt_merge.
//
// Use: items enter on i_in_valid/o_in_ready, results leave on
// o_out_valid/i_out_ready, one result per item. Configuration is written on
// i_cfg_we with i_cfg_idx (0 aliveness period, 1 sweep period) and i_cfg_data.
// The entries sit in a ring of cells, one entry per cell, kept sorted by
// client address and port. Each item makes one pass, which may be empty:
// each cycle the entry in cell 0 leaves the ring through the merge unit and is
// written back (kept, updated, dropped, or preceded by a new entry) while the
// ring shifts by one.
// Steps: accept, then the pass, then the result is loaded into the output
// register. The pass covers every occupied cell, plus one slot for an insert
// or learn item when the table is not full; a skipped sweep has no pass. The
// next item is accepted only after the previous result has been loaded.
// Reset empties the table, clears the sweep time and loads the default
// periods. When the receiver stalls, the finished result waits in the output
// register; the next item is still accepted and run, but its result then holds
// the block until the register is taken, and no further item is accepted.
module sorted_flow_route_table import sfrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    t_state           r_state;
    t_state           n_state;
    logic [23:0]      r_alive;
    logic [23:0]      r_sweep_per;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [31:0]      r_last_sweep;
    t_in_item         r_item;
    logic             r_skip;
    logic             r_ins_ok;
    logic [CNT_W-1:0] r_step;
    logic [CNT_W-1:0] r_total;
    logic [IDX_W-1:0] r_tail;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             w_acc;
    logic             w_step;
    logic             w_load;
    logic             w_a_sweep;
    logic             w_a_skip;
    logic             w_a_ins_ok;
    logic [31:0]      w_a_since;
    logic [CNT_W-1:0] w_a_total;
    logic             w_sweep;

    t_merge_ctl       w_ctl;
    t_merge_res       w_res;
    logic             w_wr;
    t_entry           w_entry;
    t_entry           w_cell [DEPTH];

    // decisions taken at accept
    assign w_a_sweep  = i_in_item.func == FN_SWEEP;
    assign w_a_since  = i_in_item.now - r_last_sweep;
    assign w_a_skip   = w_a_sweep && (w_a_since < {8'd0, r_sweep_per});
    assign w_a_ins_ok = ((i_in_item.func == FN_INSERT) || (i_in_item.func == FN_LEARN))
                        && (r_count < CNT_W'(DEPTH));
    assign w_a_total  = w_a_skip ? '0 : (r_count + CNT_W'(w_a_ins_ok));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (w_a_total == '0) ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (r_step == r_total - CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_step     = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_RUN:   w_step     = 1'b1;
            S_DONE:  w_load     = !r_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign w_acc   = i_in_valid & o_in_ready;
    assign w_sweep = r_item.func == FN_SWEEP;

    always_comb begin
        w_ctl.start    = w_acc;
        w_ctl.step     = w_step;
        w_ctl.head_vld = r_step < r_count;
        w_ctl.ins_ok   = r_ins_ok;
        w_ctl.sweep    = w_sweep;
    end

    sfrt_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_item  (r_item),
        .i_alive (r_alive),
        .i_head  (w_cell[0]),
        .o_wr    (w_wr),
        .o_entry (w_entry),
        .o_res   (w_res)
    );

    // ring: every cell takes its right neighbor, the tail cell takes the merge output when it writes
    for (genvar g = 0; g < DEPTH; g++) begin : g_ring
        sfrt_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_step),
            .i_load  (w_step & w_wr & (r_tail == IDX_W'(g))),
            .i_next  (w_cell[(g + 1) % DEPTH]),
            .i_wdata (w_entry),
            .o_entry (w_cell[g])
        );
    end

    // result
    always_comb begin
        n_count = r_count;
        n_out   = '0;
        if (r_skip) begin
            n_out.status = STS_SKIPPED;
        end else if (w_sweep) begin
            n_count             = r_count - w_res.removed;
            n_out.status        = STS_SWEPT;
            n_out.removed_count = 11'(w_res.removed);
        end else if (w_res.found) begin
            n_out.status       = STS_FOUND;
            n_out.route_ip     = w_res.gw[47:16];
            n_out.route_port   = w_res.gw[15:0];
            n_out.last_receive = w_res.rx;
        end else if (w_res.inserted) begin
            n_count            = r_count + CNT_W'(1);
            n_out.status       = STS_INSERTED;
            n_out.route_ip     = r_item.gateway_ip;
            n_out.route_port   = r_item.gateway_port;
            n_out.last_receive = r_item.now;
        end else if (r_item.func == FN_FIND) begin
            n_out.status = STS_ABSENT;
        end else begin
            n_out.status = STS_FULL;
        end
        n_out.occupancy = 11'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_alive      <= ALIVE_RESET;
            r_sweep_per  <= SWEEP_RESET;
            r_count      <= '0;
            r_last_sweep <= '0;
            r_skip       <= 1'b0;
            r_ins_ok     <= 1'b0;
            r_step       <= '0;
            r_total      <= '0;
            r_tail       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ALIVE: r_alive     <= i_cfg_data;
                    CFG_SWEEP: r_sweep_per <= i_cfg_data;
                    default:   r_alive     <= r_alive;
                endcase
            end
            if (w_acc) begin
                r_skip   <= w_a_skip;
                r_ins_ok <= w_a_ins_ok;
                r_step   <= '0;
                r_total  <= w_a_total;
                r_tail   <= IDX_W'(w_a_total - CNT_W'(1));
            end else if (w_step) begin
                r_step <= r_step + CNT_W'(1);
                // tail stays put while writing; each skipped write pulls it down
                if (!w_wr) begin
                    r_tail <= r_tail - IDX_W'(1);
                end
            end
            if (w_load) begin
                r_count <= n_count;
                if (w_sweep && !r_skip) begin
                    r_last_sweep <= r_item.now;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= i_in_item;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
